>>> src/rv32_pkg.sv
// Package: operation codes, sequencer states and widths for the RV32IM execute block.
`default_nettype none
package rv32_pkg;
    localparam int XLEN = 32;
    localparam int OP_W = 5;
    localparam int REG_IDX_W = 5;
    localparam int REGISTER_COUNT_DEF = 32;

    localparam logic [OP_W-1:0] OP_LUI   = 5'd0;
    localparam logic [OP_W-1:0] OP_AUIPC = 5'd1;
    localparam logic [OP_W-1:0] OP_JAL   = 5'd2;
    localparam logic [OP_W-1:0] OP_JALR  = 5'd3;
    localparam logic [OP_W-1:0] OP_ADDI  = 5'd4;
    localparam logic [OP_W-1:0] OP_SLTI  = 5'd5;
    localparam logic [OP_W-1:0] OP_SLTIU = 5'd6;
    localparam logic [OP_W-1:0] OP_XORI  = 5'd7;
    localparam logic [OP_W-1:0] OP_ORI   = 5'd8;
    localparam logic [OP_W-1:0] OP_ANDI  = 5'd9;
    localparam logic [OP_W-1:0] OP_SLLI  = 5'd10;
    localparam logic [OP_W-1:0] OP_SRLI  = 5'd11;
    localparam logic [OP_W-1:0] OP_SRAI  = 5'd12;
    localparam logic [OP_W-1:0] OP_ADD   = 5'd13;
    localparam logic [OP_W-1:0] OP_SUB   = 5'd14;
    localparam logic [OP_W-1:0] OP_SLL   = 5'd15;
    localparam logic [OP_W-1:0] OP_SLT   = 5'd16;
    localparam logic [OP_W-1:0] OP_SLTU  = 5'd17;
    localparam logic [OP_W-1:0] OP_XOR   = 5'd18;
    localparam logic [OP_W-1:0] OP_SRL   = 5'd19;
    localparam logic [OP_W-1:0] OP_SRA   = 5'd20;
    localparam logic [OP_W-1:0] OP_OR    = 5'd21;
    localparam logic [OP_W-1:0] OP_AND   = 5'd22;
    localparam logic [OP_W-1:0] OP_MUL   = 5'd23;
    localparam logic [OP_W-1:0] OP_MULH  = 5'd24;
    localparam logic [OP_W-1:0] OP_MULHU = 5'd25;
    localparam logic [OP_W-1:0] OP_DIV   = 5'd26;
    localparam logic [OP_W-1:0] OP_DIVU  = 5'd27;
    localparam logic [OP_W-1:0] OP_REM   = 5'd28;
    localparam logic [OP_W-1:0] OP_REMU  = 5'd29;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EXEC,
        ST_DIV,
        ST_FIX,
        ST_OUT
    } exec_state_t;

    // divider handshake
    typedef struct packed {
        logic            start;
        logic            is_signed;
        logic            want_rem;
        logic [XLEN-1:0] dividend;
        logic [XLEN-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic            done;
        logic [XLEN-1:0] result;
    } div_rsp_t;
endpackage
`default_nettype wire

>>> src/rv32_div.sv
// Radix-2 restoring divider: one quotient bit per cycle, RISC-V corner cases.
`default_nettype none
module rv32_div (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire rv32_pkg::div_req_t req,
    output rv32_pkg::div_rsp_t     rsp
);
    import rv32_pkg::*;

    localparam int CNT_W = $clog2(XLEN + 1);

    logic [XLEN-1:0]  rem_reg, rem_next;
    logic [XLEN-1:0]  quo_reg, quo_next;
    logic [XLEN-1:0]  dsr_reg, dsr_next;
    logic [XLEN-1:0]  special_reg, special_next;
    logic             use_special_reg, use_special_next;
    logic             neg_q_reg, neg_q_next;
    logic             neg_r_reg, neg_r_next;
    logic             want_rem_reg, want_rem_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [XLEN-1:0]  a_mag, b_mag;
    // partial remainder can reach the top bit, so the shift keeps one extra bit
    logic [XLEN+1:0]  trial;
    logic [XLEN:0]    shifted;
    logic [XLEN-1:0]  fin_q, fin_r;

    always_comb
    begin
        a_mag = (req.is_signed && req.dividend[XLEN-1]) ? (~req.dividend + 1'b1) : req.dividend;
        b_mag = (req.is_signed && req.divisor[XLEN-1]) ? (~req.divisor + 1'b1) : req.divisor;
        shifted = {rem_reg, quo_reg[XLEN-1]};
        trial = {1'b0, shifted} - {2'b00, dsr_reg};
        fin_q = neg_q_reg ? (~quo_reg + 1'b1) : quo_reg;
        fin_r = neg_r_reg ? (~rem_reg + 1'b1) : rem_reg;

        rem_next = rem_reg;
        quo_next = quo_reg;
        dsr_next = dsr_reg;
        special_next = special_reg;
        use_special_next = use_special_reg;
        neg_q_next = neg_q_reg;
        neg_r_next = neg_r_reg;
        want_rem_next = want_rem_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (req.start)
        begin
            rem_next = '0;
            quo_next = a_mag;
            dsr_next = b_mag;
            want_rem_next = req.want_rem;
            neg_q_next = req.is_signed && (req.dividend[XLEN-1] ^ req.divisor[XLEN-1]);
            neg_r_next = req.is_signed && req.dividend[XLEN-1];
            // divide by zero; signed overflow falls out of the normal path
            use_special_next = (req.divisor == '0);
            special_next = req.want_rem ? req.dividend : '1;
            cnt_next = CNT_W'(XLEN);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                if (!trial[XLEN+1])
                begin
                    rem_next = trial[XLEN-1:0];
                    quo_next = {quo_reg[XLEN-2:0], 1'b1};
                end
                else
                begin
                    rem_next = shifted[XLEN-1:0];
                    quo_next = {quo_reg[XLEN-2:0], 1'b0};
                end
                cnt_next = cnt_reg - 1'b1;
            end
        end

        rsp.done = done_reg;
        rsp.result = use_special_reg ? special_reg : (want_rem_reg ? fin_r : fin_q);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
        special_reg <= special_next;
        use_special_reg <= use_special_next;
        neg_q_reg <= neg_q_next;
        neg_r_reg <= neg_r_next;
        want_rem_reg <= want_rem_next;
    end
endmodule
`default_nettype wire

>>> src/rv32im_integer_execute.sv
// Top level: RV32IM execute stage with register file, ALU and shared divider.
// Sequence: an accepted ALU or jump op passes ST_READ, ST_EXEC and ST_OUT, then
//   m_tvalid rises; mul ops add ST_FIX (product registered first), div/rem ST_DIV, ST_FIX.
// Flow: one request at a time; s_tready is high only when idle with no result
//   waiting, so a new request is not taken until the last result has been taken.
// Reset: rst_n asynchronous active low clears the sequencer, output valid and
//   all register file valid bits, so every register reads zero after reset.
`default_nettype none
module rv32im_integer_execute #(
    parameter int REGISTER_COUNT = rv32_pkg::REGISTER_COUNT_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // op[4:0], dest_reg[9:5], src1_reg[14:10], src2_reg[19:15], imm[51:20], cur_pc[83:52]
    input  wire logic [87:0]  s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // write_value[31:0], write_enable[32], next_pc[64:33], jumped[65], illegal[66]
    output logic [71:0]       m_tdata
);
    import rv32_pkg::*;

    localparam int RF_IDX_W = $clog2(REGISTER_COUNT);

    exec_state_t state_reg, state_next;

    // captured request
    logic [OP_W-1:0]      op_reg;
    logic [REG_IDX_W-1:0] rd_reg, rs1_reg, rs2_reg;
    logic [XLEN-1:0]      imm_reg, pc_reg;
    logic [XLEN-1:0]      a_reg, b_reg;

    // result register
    logic [XLEN-1:0] val_reg, val_next;
    logic [XLEN-1:0] npc_reg, npc_next;
    logic            we_reg, we_next, jmp_reg, jmp_next, ill_reg, ill_next;
    logic            mvalid_reg;

    // register file: flops with per-entry valid bits
    logic [XLEN-1:0]           rf_mem [REGISTER_COUNT];
    logic [REGISTER_COUNT-1:0] rf_vld_reg;

    // multiplier product, registered before use
    logic [2*XLEN-1:0] prod_reg;

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic accept;
    logic [XLEN-1:0] i12, j21, link, alu_val;
    logic [XLEN-1:0] alu_b;
    logic [4:0]      shamt;
    logic            is_div, is_mul, legal;
    logic            rf_write;

    assign accept = s_tvalid && s_tready;
    // result register is not overwritten while a result still waits
    assign s_tready = (state_reg == ST_IDLE) && !mvalid_reg;
    assign m_tvalid = mvalid_reg;
    assign m_tdata = {5'd0, ill_reg, jmp_reg, npc_reg, we_reg, val_reg};

    assign i12  = {{20{imm_reg[11]}}, imm_reg[11:0]};
    assign j21  = {{11{imm_reg[20]}}, imm_reg[20:0]};
    assign link = pc_reg + 32'd4;
    assign is_div = (op_reg == OP_DIV) || (op_reg == OP_DIVU)
                 || (op_reg == OP_REM) || (op_reg == OP_REMU);
    assign is_mul = (op_reg == OP_MUL) || (op_reg == OP_MULH) || (op_reg == OP_MULHU);
    assign legal = (op_reg <= OP_REMU);

    // mulh sign correction from the unsigned product
    logic [XLEN-1:0] mulh_val;
    assign mulh_val = prod_reg[2*XLEN-1:XLEN]
                    - (a_reg[XLEN-1] ? b_reg : '0)
                    - (b_reg[XLEN-1] ? a_reg : '0);

    always_comb
    begin
        alu_b = (op_reg >= OP_ADD) ? b_reg : i12;
        shamt = (op_reg >= OP_ADD) ? b_reg[4:0] : imm_reg[4:0];
        case (op_reg)
            OP_LUI:                     alu_val = imm_reg;
            OP_AUIPC:                   alu_val = pc_reg + imm_reg;
            OP_JAL, OP_JALR:            alu_val = link;
            OP_ADDI, OP_ADD:            alu_val = a_reg + alu_b;
            OP_SUB:                     alu_val = a_reg - b_reg;
            OP_SLTI, OP_SLT:            alu_val = {31'd0, $signed(a_reg) < $signed(alu_b)};
            OP_SLTIU, OP_SLTU:          alu_val = {31'd0, a_reg < alu_b};
            OP_XORI, OP_XOR:            alu_val = a_reg ^ alu_b;
            OP_ORI, OP_OR:              alu_val = a_reg | alu_b;
            OP_ANDI, OP_AND:            alu_val = a_reg & alu_b;
            OP_SLLI, OP_SLL:            alu_val = a_reg << shamt;
            OP_SRLI, OP_SRL:            alu_val = a_reg >> shamt;
            OP_SRAI, OP_SRA:            alu_val = XLEN'($signed(a_reg) >>> shamt);
            OP_MUL:                     alu_val = prod_reg[XLEN-1:0];
            OP_MULH:                    alu_val = mulh_val;
            OP_MULHU:                   alu_val = prod_reg[2*XLEN-1:XLEN];
            default:                    alu_val = '0;
        endcase
    end

    // next state; mul ops pass through ST_FIX so the product is ready
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept) state_next = ST_READ;
            ST_READ: state_next = ST_EXEC;
            ST_EXEC: state_next = is_div ? ST_DIV : (is_mul ? ST_FIX : ST_OUT);
            ST_DIV:  if (div_rsp.done) state_next = ST_FIX;
            ST_FIX:  state_next = ST_OUT;
            ST_OUT:  if (!mvalid_reg || m_tready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        val_next = val_reg;
        npc_next = npc_reg;
        we_next  = we_reg;
        jmp_next = jmp_reg;
        ill_next = ill_reg;
        div_req.start = 1'b0;
        div_req.is_signed = (op_reg == OP_DIV) || (op_reg == OP_REM);
        div_req.want_rem = (op_reg == OP_REM) || (op_reg == OP_REMU);
        div_req.dividend = a_reg;
        div_req.divisor = b_reg;
        rf_write = 1'b0;
        unique case (state_reg)
            ST_EXEC:
            begin
                ill_next = !legal;
                jmp_next = (op_reg == OP_JAL) || (op_reg == OP_JALR);
                we_next  = legal && (rd_reg != '0) && (32'(rd_reg) < REGISTER_COUNT);
                val_next = legal ? alu_val : '0;
                if (op_reg == OP_JAL)
                    npc_next = pc_reg + j21;
                else if (op_reg == OP_JALR)
                    npc_next = (a_reg + i12) & ~32'd1;
                else
                    npc_next = link;
                div_req.start = is_div;
                rf_write = !is_div && !is_mul;
            end
            ST_FIX:
            begin
                val_next = is_div ? div_rsp.result : alu_val;
                rf_write = 1'b1;
            end
            default: ;
        endcase
    end

    rv32_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            mvalid_reg <= 1'b0;
            rf_vld_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_OUT && state_next == ST_IDLE)
                mvalid_reg <= 1'b1;
            else if (m_tready)
                mvalid_reg <= 1'b0;
            if (rf_write && we_next)
                rf_vld_reg[rd_reg[RF_IDX_W-1:0]] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= s_tdata[4:0];
            rd_reg  <= s_tdata[9:5];
            rs1_reg <= s_tdata[14:10];
            rs2_reg <= s_tdata[19:15];
            imm_reg <= s_tdata[51:20];
            pc_reg  <= s_tdata[83:52];
        end
        // register read; out-of-range or never-written entries read zero
        if (state_reg == ST_READ)
        begin
            a_reg <= (32'(rs1_reg) < REGISTER_COUNT && rf_vld_reg[rs1_reg[RF_IDX_W-1:0]])
                   ? rf_mem[rs1_reg[RF_IDX_W-1:0]] : '0;
            b_reg <= (32'(rs2_reg) < REGISTER_COUNT && rf_vld_reg[rs2_reg[RF_IDX_W-1:0]])
                   ? rf_mem[rs2_reg[RF_IDX_W-1:0]] : '0;
        end
        prod_reg <= a_reg * b_reg;
        if (rf_write && we_next)
            rf_mem[rd_reg[RF_IDX_W-1:0]] <= val_next;
        val_reg <= val_next;
        npc_reg <= npc_next;
        we_reg  <= we_next;
        jmp_reg <= jmp_next;
        ill_reg <= ill_next;
    end
endmodule
`default_nettype wire

>>> sim/rv32im_integer_execute_tb.sv
// Testbench for the RV32IM execute stage: random and directed requests against a local predictor.
`default_nettype none
module rv32im_integer_execute_tb;
    import rv32_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NREGS = 32;
    localparam int STALL_LIMIT = 4000;

    // packed from the top bit down, matching m_tdata[66:0]
    typedef struct packed {
        logic        ill;
        logic        jmp;
        logic [31:0] npc;
        logic        wen;
        logic [31:0] wval;
    } exec_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    // op, dest_reg, src1_reg, src2_reg, imm, cur_pc (from bit 0 up)
    logic [87:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    // write_value, write_enable, next_pc, jumped, illegal (from bit 0 up)
    logic [71:0] m_tdata;

    rv32im_integer_execute uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // shadow register file and queue of predicted write-backs
    logic [31:0]  shadow_regs [NREGS];
    exec_result_t pending_results [$];
    int           errors = 0;
    int           sent = 0;
    int           checked = 0;
    int           idle_cycles = 0;
    bit           quiet_mode = 0;   // no stalls or gaps near the end
    bit           tx_gaps = 1;

    initial clk = 1'b0;
    always #10 clk = ~clk;

    function automatic logic [31:0] sx(input logic [31:0] v, input int bits);
        logic [31:0] m;
        m = (bits >= 32) ? '1 : ((32'd1 << bits) - 1);
        return ((v & m) ^ (32'd1 << (bits - 1))) - (32'd1 << (bits - 1));
    endfunction

    function automatic logic [31:0] read_shadow(input logic [4:0] idx);
        return (idx == 0) ? 32'd0 : shadow_regs[idx];
    endfunction

    // Predict one instruction and update the shadow register file.
    function automatic exec_result_t execute_instr(input logic [4:0] op, input logic [4:0] rd,
            input logic [4:0] rs1, input logic [4:0] rs2, input logic [31:0] imm,
            input logic [31:0] pc);
        logic [31:0] a, b, i12, link, v;
        logic [63:0] prod;
        exec_result_t r;
        a = read_shadow(rs1);
        b = read_shadow(rs2);
        i12 = sx(imm, 12);
        link = pc + 32'd4;
        v = '0;
        r = '0;
        r.npc = link;
        case (op)
            OP_LUI:   v = imm;
            OP_AUIPC: v = pc + imm;
            OP_JAL:   begin v = link; r.npc = pc + sx(imm, 21); r.jmp = 1; end
            OP_JALR:  begin v = link; r.npc = (a + i12) & ~32'd1; r.jmp = 1; end
            OP_ADDI:  v = a + i12;
            OP_SLTI:  v = {31'd0, $signed(a) < $signed(i12)};
            OP_SLTIU: v = {31'd0, a < i12};
            OP_XORI:  v = a ^ i12;
            OP_ORI:   v = a | i12;
            OP_ANDI:  v = a & i12;
            OP_SLLI:  v = a << imm[4:0];
            OP_SRLI:  v = a >> imm[4:0];
            OP_SRAI:  v = $signed(a) >>> imm[4:0];
            OP_ADD:   v = a + b;
            OP_SUB:   v = a - b;
            OP_SLL:   v = a << b[4:0];
            OP_SLT:   v = {31'd0, $signed(a) < $signed(b)};
            OP_SLTU:  v = {31'd0, a < b};
            OP_XOR:   v = a ^ b;
            OP_SRL:   v = a >> b[4:0];
            OP_SRA:   v = $signed(a) >>> b[4:0];
            OP_OR:    v = a | b;
            OP_AND:   v = a & b;
            OP_MUL:   begin prod = a * b; v = prod[31:0]; end
            OP_MULH:  begin
                prod = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
                v = prod[63:32];
            end
            OP_MULHU: begin prod = {32'd0, a} * {32'd0, b}; v = prod[63:32]; end
            OP_DIV, OP_REM: begin
                if (b == 0)
                    v = (op == OP_REM) ? a : '1;
                else if (a == 32'h8000_0000 && b == '1)
                    v = (op == OP_REM) ? 32'd0 : 32'h8000_0000;
                else if (op == OP_REM)
                    v = $signed(a) % $signed(b);
                else
                    v = $signed(a) / $signed(b);
            end
            OP_DIVU:  v = (b == 0) ? '1 : a / b;
            OP_REMU:  v = (b == 0) ? a : a % b;
            default:  r.ill = 1;
        endcase
        r.wval = r.ill ? 32'd0 : v;
        r.wen = !r.ill && rd != 0;
        if (r.wen)
            shadow_regs[rd] = v;
        return r;
    endfunction

    // Send one request, predicting its result at acceptance.
    task automatic send_instr(input logic [4:0] op, input logic [4:0] rd, input logic [4:0] rs1,
            input logic [4:0] rs2, input logic [31:0] imm, input logic [31:0] pc);
        int gap;
        if (tx_gaps && !quiet_mode && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 16);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tdata <= {4'd0, pc, imm, rs2, rs1, rd, op};
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
        pending_results.push_back(execute_instr(op, rd, rs1, rs2, imm, pc));
        sent++;
        @(negedge clk);
        s_tvalid <= 1'b0;
        // block is busy after an accept anyway, with s_tready low until it is idle again
        @(negedge clk);
    endtask

    task automatic wait_drained;
        while (pending_results.size() != 0) @(negedge clk);
    endtask

    // Load x1 to x31 with random values through lui; the write to x0 is discarded
    task automatic test_register_load;
        for (int i = 0; i < NREGS; i++)
            send_instr(OP_LUI, i[4:0], 5'd0, 5'd0, $urandom, $urandom);
    endtask

    // Extremes and special cases, one handful of requests
    task automatic test_directed;
        send_instr(OP_LUI, 5'd1, 5'd0, 5'd0, 32'h8000_0000, 32'hFFFF_FFFC);
        send_instr(OP_LUI, 5'd2, 5'd0, 5'd0, 32'hFFFF_FFFF, 32'd0);
        send_instr(OP_LUI, 5'd3, 5'd0, 5'd0, 32'd0, 32'd0);
        send_instr(OP_DIV, 5'd4, 5'd1, 5'd2, 32'd0, 32'd0);        // signed overflow
        send_instr(OP_REM, 5'd5, 5'd1, 5'd2, 32'd0, 32'd0);
        send_instr(OP_DIV, 5'd6, 5'd1, 5'd3, 32'd0, 32'd0);        // divide by zero
        send_instr(OP_DIVU, 5'd6, 5'd2, 5'd3, 32'd0, 32'd0);
        send_instr(OP_REM, 5'd7, 5'd1, 5'd3, 32'd0, 32'd0);
        send_instr(OP_REMU, 5'd7, 5'd2, 5'd0, 32'd0, 32'd0);
        send_instr(OP_ADD, 5'd0, 5'd1, 5'd2, 32'd0, 32'd0);        // x0 discards the write
        send_instr(OP_JALR, 5'd2, 5'd2, 5'd0, 32'hFFF, 32'h10);    // dest equals source
        send_instr(OP_JAL, 5'd8, 5'd0, 5'd0, 32'h0010_0000, 32'hFFFF_FFFC);
        send_instr(OP_JAL, 5'd8, 5'd0, 5'd0, 32'h000F_FFFE, 32'h0);
        send_instr(OP_SRAI, 5'd9, 5'd1, 5'd0, 32'hFFFF_FFFF, 32'd0); // high imm bits ignored
        send_instr(OP_SLLI, 5'd9, 5'd2, 5'd0, 32'hFFFF_FFE0, 32'd0);
        send_instr(5'd30, 5'd10, 5'd1, 5'd2, '1, '1);       // unsupported
        send_instr(5'd31, 5'd10, 5'd1, 5'd2, '1, '1);
        send_instr(OP_MULH, 5'd11, 5'd1, 5'd1, 32'd0, 32'd0);
        send_instr(OP_MULHU, 5'd11, 5'd2, 5'd2, 32'd0, 32'd0);
        send_instr(OP_SLTI, 5'd12, 5'd1, 5'd0, 32'h800, 32'd0);
        send_instr(OP_SLTIU, 5'd12, 5'd3, 5'd0, 32'hFFF, 32'd0);
        wait_drained;                                       // sender holds off here
    endtask

    // Random instructions; some immediates are small or have upper 20 bits all ones or all zeros
    task automatic test_random(input int count);
        logic [31:0] imm;
        logic [4:0]  op;
        for (int n = 0; n < count; n++) begin
            op = 5'($urandom_range(0, 31));
            case ($urandom_range(0, 3))
                0: imm = $urandom_range(0, 15);
                1: imm = {$urandom_range(0, 1) ? 20'hFFFFF : 20'h0, 12'($urandom)};
                default: imm = $urandom;
            endcase
            send_instr(op, 5'($urandom), 5'($urandom), 5'($urandom), imm, $urandom);
        end
    endtask

    // Result checker and receiver stalls
    always @(posedge clk) begin
        exec_result_t got, want;
        if (rst_n && m_tvalid && m_tready) begin
            got = m_tdata[66:0];
            checked++;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (got !== want || m_tdata[71:67] !== 5'd0) begin
                    $display("%0t: mismatch expected wv=%h we=%b npc=%h j=%b il=%b",
                             $time, want.wval, want.wen, want.npc, want.jmp, want.ill);
                    $display("%0t:          actual   wv=%h we=%b npc=%h j=%b il=%b",
                             $time, got.wval, got.wen, got.npc, got.jmp, got.ill);
                    errors++;
                end
            end
        end
    end

    int stall_left = 0;
    always @(negedge clk) begin
        if (quiet_mode) begin
            m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 15);
            m_tready <= 1'b0;
        end else
            m_tready <= 1'b1;
    end

    // Watchdog: cycles without any handshake
    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < NREGS; i++)
            shadow_regs[i] = '0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_random(20);           // reads of reset-zero registers
        test_register_load;
        test_directed;
        test_random(1200);
        tx_gaps = 0;
        test_random(100);
        test_register_load;
        quiet_mode = 1;
        test_random(150);
        wait_drained;
        repeat (50) @(negedge clk);
        $display("Covered %0d requests, %0d results checked: all ops, jumps, x0,", sent, checked);
        $display("divide corner cases and unsupported op codes, with stalls both sides.");
        if (errors == 0 && pending_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
`default_nettype wire
